FILE: rtl/brrl_pkg.sv
// Package of the row-run labeler: payload types and default sizes.
package brrl_pkg;

    localparam int GRID_WIDTH_DEF = 32;
    localparam int MAX_RUNS_DEF   = 16;
    localparam int MAX_LABELS_DEF = 256;
    localparam int MAX_ROWS_DEF   = 1024;
    localparam int RESULT_CAP     = 64;

    localparam logic REC_RUN  = 1'b0;
    localparam logic REC_PAIR = 1'b1;

    localparam logic [1:0] EV_FRESH = 2'd0;
    localparam logic [1:0] EV_CONT  = 2'd1;
    localparam logic [1:0] EV_SPLIT = 2'd2;
    localparam logic [1:0] EV_MERGE = 2'd3;

    typedef struct packed {
        logic [31:0] row_bits;
        logic        first_row;
    } in_item_t;

    typedef struct packed {
        logic       record_kind;
        logic [9:0] row_index;
        logic [4:0] col_start;
        logic [4:0] col_end;
        logic [7:0] cell_label;
        logic [7:0] parent_label;
        logic [1:0] run_event;
        logic       label_overflow;
        logic       last;
    } out_item_t;

endpackage

FILE: rtl/boustrophedon_row_run_labeler_top.sv
// Top level of the boustrophedon row-run labeler.
//
// Usage: present one occupancy-grid row per beat on s_data (s_valid/s_ready).
// Set first_row on the first row of a map to clear labels, the row count and
// the stored runs. Each row yields zero or more result beats on m_data
// (m_valid/m_ready): a run record per run, left to right, each followed by
// its neighbour pair records on a split or merge; last marks the final beat
// of the row. An empty row yields no beat and clears the stored runs.
// Flow: a row is accepted, then scanned (the row bits shift out one column
// per cycle), then each run is evaluated, labelled and followed by its
// neighbour pair records, then a closing step flushes the last beat; an
// empty row skips the run steps. Receiver stalls hold the labelling, pair
// and closing steps. The single sequencer below sets the pace; s_ready is
// high only between rows. Records past RESULT_CAP in a row are dropped.
// Reset (aresetn low, synchronous) clears the sequencer, the counters, the
// stored run count and the output valids.
// A stalled receiver holds m_data; the sequencer waits when its one-record
// hold stage and the output register are both full; no kept record is lost.
module boustrophedon_row_run_labeler_top #(
    parameter int GRID_WIDTH = brrl_pkg::GRID_WIDTH_DEF,
    parameter int MAX_RUNS   = brrl_pkg::MAX_RUNS_DEF,
    parameter int MAX_LABELS = brrl_pkg::MAX_LABELS_DEF,
    parameter int MAX_ROWS   = brrl_pkg::MAX_ROWS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  brrl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output brrl_pkg::out_item_t m_data
);

    // columns past bit 31 of the input are always clear
    localparam int SCAN_LEN = (GRID_WIDTH < 32) ? GRID_WIDTH : 32;
    localparam int CW   = $clog2(SCAN_LEN);
    localparam int RI_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RC_W = $clog2(MAX_RUNS + 1);
    localparam int LW   = $clog2(MAX_LABELS);
    localparam int NLW  = $clog2(MAX_LABELS + 1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int KW   = $clog2(brrl_pkg::RESULT_CAP + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_EVAL, ST_KIDS, ST_LABEL, ST_PAIRS, ST_DONE
    } state_t;

    state_t state_reg;

    logic [SCAN_LEN-1:0] bits_reg;
    logic [CW-1:0]       col_reg;
    logic                in_run_reg;   // inside a tracked run
    logic                drop_run_reg; // inside a run past the run limit
    logic [RC_W-1:0]     n_reg;
    logic [RI_W-1:0]     last_idx_reg;

    logic [CW-1:0] cs_reg [MAX_RUNS];
    logic [CW-1:0] ce_reg [MAX_RUNS];
    logic [LW-1:0] cl_reg [MAX_RUNS];
    logic [CW-1:0] ps_reg [MAX_RUNS];
    logic [CW-1:0] pe_reg [MAX_RUNS];
    logic [LW-1:0] pl_reg [MAX_RUNS];
    logic [RC_W-1:0] pc_reg;

    logic [NLW-1:0] nl_reg;
    logic [RW-1:0]  row_cnt_reg;
    logic [RW-1:0]  row_reg;

    logic [RI_W-1:0]     cur_reg;
    logic [MAX_RUNS-1:0] ovl_reg;
    logic [RI_W-1:0]     first_reg;
    logic                np0_reg;
    logic                np1_reg;
    logic                kids1_reg;
    logic [LW-1:0]       lab_reg;
    logic [1:0]          ev_reg;
    logic [KW-1:0]       k_reg;

    logic                hold_valid_reg;
    brrl_pkg::out_item_t hold_reg;
    logic                m_valid_reg;
    brrl_pkg::out_item_t m_data_reg;

    // overlap of the current run with every stored run
    logic [MAX_RUNS-1:0] ovl_next;
    logic [RI_W-1:0]     first_next;
    always_comb begin
        first_next = '0;
        for (int j = 0; j < MAX_RUNS; j++) begin
            ovl_next[j] = (RC_W'(j) < pc_reg) && (cs_reg[cur_reg] <= pe_reg[j])
                          && (ps_reg[j] <= ce_reg[cur_reg]);
        end
        for (int j = MAX_RUNS - 1; j >= 0; j--) begin
            if (ovl_next[j]) begin
                first_next = RI_W'(j);
            end
        end
    end

    // children of the first parent among this row's runs
    logic [MAX_RUNS-1:0] kid_vec;
    always_comb begin
        for (int i = 0; i < MAX_RUNS; i++) begin
            kid_vec[i] = (RC_W'(i) < n_reg) && (cs_reg[i] <= pe_reg[first_reg])
                         && (ps_reg[first_reg] <= ce_reg[i]);
        end
    end

    // lowest pending parent in the pair pass
    logic [RI_W-1:0] pj_next;
    always_comb begin
        pj_next = '0;
        for (int j = MAX_RUNS - 1; j >= 0; j--) begin
            if (ovl_reg[j]) begin
                pj_next = RI_W'(j);
            end
        end
    end

    // fresh label with saturation
    logic           lab_sat;
    logic [LW-1:0]  fresh_lab;
    logic [NLW-1:0] nl_inc;
    assign lab_sat   = (nl_reg >= NLW'(MAX_LABELS));
    assign fresh_lab = lab_sat ? LW'(MAX_LABELS - 1) : nl_reg[LW-1:0];
    assign nl_inc    = lab_sat ? nl_reg : nl_reg + NLW'(1);

    logic           use_fresh;
    logic [LW-1:0]  run_lab;
    logic [1:0]     run_ev;
    logic [NLW-1:0] nl_after;
    always_comb begin
        use_fresh = 1'b1;
        run_ev    = brrl_pkg::EV_FRESH;
        if (np0_reg) begin
            run_ev = brrl_pkg::EV_FRESH;
        end else if (np1_reg && kids1_reg) begin
            use_fresh = 1'b0;
            run_ev    = brrl_pkg::EV_CONT;
        end else if (np1_reg) begin
            run_ev = brrl_pkg::EV_SPLIT;
        end else begin
            run_ev = brrl_pkg::EV_MERGE;
        end
        run_lab  = use_fresh ? fresh_lab : pl_reg[first_reg];
        nl_after = use_fresh ? nl_inc : nl_reg;
    end

    // record built this cycle
    logic                want;
    brrl_pkg::out_item_t rec;
    always_comb begin
        want = (state_reg == ST_LABEL) || ((state_reg == ST_PAIRS) && (ovl_reg != '0));
        rec.row_index      = 10'(row_reg);
        rec.col_start      = 5'(cs_reg[cur_reg]);
        rec.col_end        = 5'(ce_reg[cur_reg]);
        rec.last           = 1'b0;
        if (state_reg == ST_LABEL) begin
            rec.record_kind    = brrl_pkg::REC_RUN;
            rec.cell_label     = 8'(run_lab);
            rec.parent_label   = '0;
            rec.run_event      = run_ev;
            rec.label_overflow = (nl_after >= NLW'(MAX_LABELS));
        end else begin
            rec.record_kind    = brrl_pkg::REC_PAIR;
            rec.cell_label     = 8'(lab_reg);
            rec.parent_label   = 8'(pl_reg[pj_next]);
            rec.run_event      = ev_reg;
            rec.label_overflow = lab_sat;
        end
    end

    logic m_free;
    logic cap_full;
    logic emit_go;
    logic last_run;
    assign m_free   = !m_valid_reg || m_ready;
    assign cap_full = (k_reg >= KW'(brrl_pkg::RESULT_CAP));
    assign emit_go  = want && (cap_full || !hold_valid_reg || m_free);
    assign last_run = (RC_W'(cur_reg) + RC_W'(1)) == n_reg;

    // load the output register: a kept record pushes the held one out, and
    // the closing cycle flushes it as the row's last beat
    logic                m_load;
    brrl_pkg::out_item_t flush_rec;
    always_comb begin
        flush_rec      = hold_reg;
        flush_rec.last = 1'b1;
    end
    assign m_load = hold_valid_reg && ((emit_go && !cap_full)
                    || ((state_reg == ST_DONE) && m_free));

    logic [RW-1:0] row_sat_inc;
    assign row_sat_inc = (row_cnt_reg < RW'(MAX_ROWS - 1)) ? row_cnt_reg + RW'(1) : row_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            nl_reg         <= '0;
            row_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            n_reg          <= '0;
            k_reg          <= '0;
        end else begin
            // reload or drain the output register
            if (m_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= (state_reg == ST_DONE) ? flush_rec : hold_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // advance the hold stage on every kept record
            if (emit_go && !cap_full) begin
                hold_valid_reg <= 1'b1;
                hold_reg       <= rec;
                k_reg          <= k_reg + KW'(1);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        bits_reg     <= s_data.row_bits[SCAN_LEN-1:0];
                        col_reg      <= '0;
                        in_run_reg   <= 1'b0;
                        drop_run_reg <= 1'b0;
                        n_reg        <= '0;
                        k_reg        <= '0;
                        if (s_data.first_row) begin
                            nl_reg      <= '0;
                            pc_reg      <= '0;
                            row_reg     <= '0;
                            row_cnt_reg <= RW'(1);
                        end else begin
                            row_reg     <= row_cnt_reg;
                            row_cnt_reg <= row_sat_inc;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    bits_reg <= bits_reg >> 1;
                    col_reg  <= col_reg + CW'(1);
                    if (!bits_reg[0]) begin
                        in_run_reg   <= 1'b0;
                        drop_run_reg <= 1'b0;
                    end else if (!in_run_reg && !drop_run_reg) begin
                        if (n_reg < RC_W'(MAX_RUNS)) begin
                            cs_reg[n_reg[RI_W-1:0]] <= col_reg;
                            ce_reg[n_reg[RI_W-1:0]] <= col_reg;
                            last_idx_reg            <= n_reg[RI_W-1:0];
                            n_reg                   <= n_reg + RC_W'(1);
                            in_run_reg              <= 1'b1;
                        end else begin
                            drop_run_reg <= 1'b1;
                        end
                    end else if (in_run_reg) begin
                        ce_reg[last_idx_reg] <= col_reg;
                    end
                    if (col_reg == CW'(SCAN_LEN - 1)) begin
                        cur_reg   <= '0;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (n_reg == '0) begin
                        pc_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        ovl_reg   <= ovl_next;
                        first_reg <= first_next;
                        np0_reg   <= (ovl_next == '0);
                        np1_reg   <= $onehot(ovl_next);
                        state_reg <= ST_KIDS;
                    end
                end
                ST_KIDS: begin
                    kids1_reg <= $onehot(kid_vec);
                    state_reg <= ST_LABEL;
                end
                ST_LABEL: begin
                    if (emit_go) begin
                        nl_reg           <= nl_after;
                        lab_reg          <= run_lab;
                        ev_reg           <= run_ev;
                        cl_reg[cur_reg]  <= run_lab;
                        if (run_ev == brrl_pkg::EV_FRESH || run_ev == brrl_pkg::EV_CONT) begin
                            ovl_reg <= '0;
                        end
                        state_reg <= ST_PAIRS;
                    end
                end
                ST_PAIRS: begin
                    if (ovl_reg == '0) begin
                        if (last_run) begin
                            state_reg <= ST_DONE;
                        end else begin
                            cur_reg   <= cur_reg + RI_W'(1);
                            state_reg <= ST_EVAL;
                        end
                    end else if (emit_go) begin
                        ovl_reg[pj_next] <= 1'b0;
                    end
                end
                ST_DONE: begin
                    // flush the held record as the row's last beat
                    if (!hold_valid_reg || m_free) begin
                        hold_valid_reg <= 1'b0;
                        for (int i = 0; i < MAX_RUNS; i++) begin
                            ps_reg[i] <= cs_reg[i];
                            pe_reg[i] <= ce_reg[i];
                            pl_reg[i] <= cl_reg[i];
                        end
                        pc_reg    <= n_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
